/* rtl/core/top_k_ranked_word_list_core_macros.svh */
// assertion macros for the top-k ranked word list core
`ifndef TOP_K_RANKED_WORD_LIST_CORE_MACROS_SVH
`define TOP_K_RANKED_WORD_LIST_CORE_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define TKW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TKW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tkw_pkg.sv */
// shared types, constants and helpers for the top-k ranked word list
package tkw_pkg;

   localparam int DEPTH      = 8;
   localparam int WORD_BYTES = 8;
   localparam int MAX_DUMP   = 8;

   localparam int KEY_W    = 64;
   localparam int LEN_W    = 4;
   localparam int SCORE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int RANK_W   = 3;
   localparam int REQ_W    = 2;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DUMP_CAP = (DEPTH < MAX_DUMP) ? DEPTH : MAX_DUMP;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LOW   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

   typedef struct packed {
      logic [KEY_W-1:0]   word;
      logic [LEN_W-1:0]   len;
      logic [SCORE_W-1:0] score;
   } entry_type;

   typedef struct packed {
      logic write_en;
      logic rotate_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic dup;
      logic point;
   } cell_stat_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      if (len > LEN_W'(WORD_BYTES)) begin
         return LEN_W'(WORD_BYTES);
      end
      return len;
   endfunction

   // zero every byte at or above len
   function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] key,
                                                 input logic [LEN_W-1:0] len);
      logic [KEY_W-1:0] res;
      res = key;
      for (int b = 0; b < KEY_W / 8; b++) begin
         if (LEN_W'(b) >= len) begin
            res[b*8 +: 8] = 8'h00;
         end
      end
      return res;
   endfunction

endpackage

/* rtl/core/top_k_ranked_word_list_core.sv */
// top level of the top-k ranked word list core
//
// Keeps up to DEPTH words sorted by descending popularity in a row of cells.
// A request is taken when start is high and busy is low; its fields sit on
// req_type, req_word_key, req_word_len and req_popularity in that cycle.
// Insert and clear finish in the accepting cycle: their single result shows
// on the rsp_ ports, marked by rsp_valid, in the next cycle, and busy stays
// low, so one insert or clear can be taken every cycle while no dump runs.
// A dump rotates the cell ring once around, one cell per cycle, with busy high
// until the rotation ends; one listed entry comes out per cycle, at most eight,
// rsp_last on the final one. A dump of an empty list gives one ST_EMPTY result.
// Each result is shown for one cycle only; the receiver must take it then.
// Reset empties the list and drops busy; the stored words need no clearing.
// A request with an unknown type is taken and gives no result.
`include "top_k_ranked_word_list_core_macros.svh"

module top_k_ranked_word_list_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tkw_pkg::REQ_W-1:0]      req_type,
   input  logic [tkw_pkg::KEY_W-1:0]      req_word_key,
   input  logic [tkw_pkg::LEN_W-1:0]      req_word_len,
   input  logic [tkw_pkg::SCORE_W-1:0]    req_popularity,
   output logic                           rsp_valid,
   output logic [tkw_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tkw_pkg::RANK_W-1:0]     rsp_rank,
   output logic [tkw_pkg::KEY_W-1:0]      rsp_out_word,
   output logic [tkw_pkg::LEN_W-1:0]      rsp_out_len,
   output logic [tkw_pkg::SCORE_W-1:0]    rsp_out_popularity,
   output logic                           rsp_last
);
   import tkw_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  dump_cnt_ff, dump_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [RANK_W-1:0]   rsp_rank_ff, rsp_rank_in;
   entry_type           rsp_entry_ff, rsp_entry_in;
   logic                rsp_last_ff, rsp_last_in;

   entry_type     new_entry;
   entry_type     cell_entry [DEPTH];
   cell_stat_type cell_stat [DEPTH];
   logic [DEPTH:0]   lower_chain;
   logic [DEPTH-1:0] point_vec, dup_vec;
   logic [IDX_W-1:0] point_idx, dup_idx;
   cell_ctrl_type ctrl;

   logic             accept, is_insert, full, reject, dup_any;
   logic [CNT_W-1:0] dump_n, dump_pos;

   assign new_entry.len   = clamp_len(req_word_len);
   assign new_entry.word  = mask_key(req_word_key, new_entry.len);
   assign new_entry.score = req_popularity;

   assign lower_chain[0] = 1'b0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      entry_type prev_e;
      if (g == 0) begin : g_head
         assign prev_e = new_entry;
      end else begin : g_body
         assign prev_e = cell_entry[g-1];
      end

      tkw_cell u_cell (
         .clock           (clock),
         .ctrl            (ctrl),
         .new_entry       (new_entry),
         .prev_entry      (prev_e),
         .next_entry      (cell_entry[(g + 1) % DEPTH]),
         .occupied        (CNT_W'(g) < count_ff),
         .at_end          (CNT_W'(g) == count_ff),
         .lower_chain_in  (lower_chain[g]),
         .lower_chain_out (lower_chain[g+1]),
         .stat            (cell_stat[g]),
         .entry           (cell_entry[g])
      );

      assign point_vec[g] = cell_stat[g].point;
      assign dup_vec[g]   = cell_stat[g].dup;
   end

   always_comb begin
      point_idx = '0;
      dup_idx   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (point_vec[i]) begin
            point_idx = point_idx | IDX_W'(i);
         end
      end
      // late copies can sit ahead of the point too, the first match wins
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (dup_vec[i]) begin
            dup_idx = IDX_W'(i);
         end
      end
   end

   assign accept    = start && !busy_ff;
   assign is_insert = accept && (req_type == REQ_INSERT);
   assign full      = (count_ff == CNT_W'(DEPTH));
   // list is sorted, so no lower score anywhere means not above the minimum
   assign reject    = full && !lower_chain[DEPTH];
   assign dup_any   = |dup_vec;

   assign ctrl.write_en  = is_insert && !reject && !dup_any;
   assign ctrl.rotate_en = busy_ff;

   assign dump_n   = (count_ff > CNT_W'(DUMP_CAP)) ? CNT_W'(DUMP_CAP) : count_ff;
   assign dump_pos = CNT_W'(dump_cnt_ff);

   always_comb begin
      count_in      = count_ff;
      busy_in       = busy_ff;
      dump_cnt_in   = dump_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;

      if (busy_ff) begin
         // cell 0 holds entry dump_cnt after that many rotations
         if (dump_pos < dump_n) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_ENTRY;
            rsp_rank_in   = RANK_W'(dump_cnt_ff);
            rsp_entry_in  = cell_entry[0];
            rsp_last_in   = (dump_pos + CNT_W'(1) == dump_n);
         end
         if (dump_cnt_ff == IDX_W'(DEPTH - 1)) begin
            busy_in     = 1'b0;
            dump_cnt_in = '0;
         end else begin
            dump_cnt_in = dump_cnt_ff + IDX_W'(1);
         end
      end else if (accept) begin
         unique case (req_type)
            REQ_INSERT: begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = new_entry;
               rsp_last_in  = 1'b1;
               if (reject) begin
                  rsp_status_in = ST_TOO_LOW;
                  rsp_rank_in   = '0;
               end else if (dup_any) begin
                  rsp_status_in = ST_DUPLICATE;
                  rsp_rank_in   = RANK_W'(dup_idx);
               end else begin
                  rsp_status_in = ST_INSERTED;
                  rsp_rank_in   = RANK_W'(point_idx);
                  if (!full) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
            REQ_CLEAR: begin
               count_in      = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_CLEARED;
               rsp_rank_in   = '0;
               rsp_entry_in  = '0;
               rsp_last_in   = 1'b1;
            end
            REQ_DUMP: begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
                  rsp_rank_in   = '0;
                  rsp_entry_in  = '0;
                  rsp_last_in   = 1'b1;
               end else begin
                  busy_in     = 1'b1;
                  dump_cnt_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy               = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_rank           = rsp_rank_ff;
   assign rsp_out_word       = rsp_entry_ff.word;
   assign rsp_out_len        = rsp_entry_ff.len;
   assign rsp_out_popularity = rsp_entry_ff.score;
   assign rsp_last           = rsp_last_ff;

   `TKW_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(DEPTH),
                   "entry count above depth")
   `TKW_ASSERT_NOW(a_one_point, 1'b1, $onehot0(point_vec),
                   "more than one insertion point")
   `TKW_ASSERT_NEXT(a_insert_answers, is_insert, rsp_valid && rsp_last,
                    "insert request gave no single result")
   `TKW_ASSERT_NEXT(a_dump_ends, busy_ff && (dump_cnt_ff == IDX_W'(DEPTH - 1)), !busy_ff,
                    "dump did not end after one full rotation")
   `TKW_ASSERT_NOW(a_no_write_in_dump, busy_ff, !ctrl.write_en,
                   "list written during dump")

endmodule

/* rtl/core/tkw_cell.sv */
// one slot of the ranked list: holds an entry, compares and shifts
module tkw_cell (
   input  logic                   clock,
   input  tkw_pkg::cell_ctrl_type ctrl,
   input  tkw_pkg::entry_type     new_entry,
   input  tkw_pkg::entry_type     prev_entry,
   input  tkw_pkg::entry_type     next_entry,
   input  logic                   occupied,
   input  logic                   at_end,
   input  logic                   lower_chain_in,
   output logic                   lower_chain_out,
   output tkw_pkg::cell_stat_type stat,
   output tkw_pkg::entry_type     entry
);
   import tkw_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      lower_here;
   logic      match_here;

   assign lower_here = occupied && (entry_ff.score < new_entry.score);
   assign match_here = occupied && (entry_ff.len == new_entry.len)
                       && (entry_ff.word == new_entry.word);

   assign lower_chain_out = lower_chain_in | lower_here;
   // a match only counts at or ahead of the insertion point
   assign stat.dup   = match_here && !lower_chain_in;
   assign stat.point = !lower_chain_in && (lower_here || at_end);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.rotate_en) begin
         entry_in = next_entry;
      end else if (ctrl.write_en) begin
         if (lower_chain_in) begin
            entry_in = prev_entry;
         end else if (stat.point) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* dv/top_k_ranked_word_list_core_tb.sv */
// self-checking testbench for the top-k ranked word list core
module top_k_ranked_word_list_core_tb;
   import tkw_pkg::*;

   localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
   localparam int RANDOM_ITEMS = 330;
   localparam int CALM_TAIL    = 40;
   localparam int POOL_SIZE    = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_CAP    = 40;

   typedef struct {
      logic [REQ_W-1:0]   kind;
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   len;
      logic [SCORE_W-1:0] pop;
      int                 gap;
      bit                 drain;
   } word_request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [RANK_W-1:0]   rank;
      logic [KEY_W-1:0]    word;
      logic [LEN_W-1:0]    len;
      logic [SCORE_W-1:0]  score;
      logic                last;
   } list_answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [REQ_W-1:0]    req_type = '0;
   logic [KEY_W-1:0]    req_word_key = '0;
   logic [LEN_W-1:0]    req_word_len = '0;
   logic [SCORE_W-1:0]  req_popularity = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [RANK_W-1:0]   rsp_rank;
   logic [KEY_W-1:0]    rsp_out_word;
   logic [LEN_W-1:0]    rsp_out_len;
   logic [SCORE_W-1:0]  rsp_out_popularity;
   logic                rsp_last;

   word_request_type pending_requests[$];
   list_answer_type  expected_answers[$];

   // predicted contents of the ranked list
   logic [KEY_W-1:0]   list_word[DEPTH];
   logic [LEN_W-1:0]   list_len[DEPTH];
   logic [SCORE_W-1:0] list_score[DEPTH];
   int                 list_count = 0;

   int mismatches   = 0;
   int answer_count = 0;
   int cycle_count  = 0;
   int gap_left     = 0;
   bit gap_armed    = 1'b0;

   top_k_ranked_word_list_core u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_word_key       (req_word_key),
      .req_word_len       (req_word_len),
      .req_popularity     (req_popularity),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_rank           (rsp_rank),
      .rsp_out_word       (rsp_out_word),
      .rsp_out_len        (rsp_out_len),
      .rsp_out_popularity (rsp_out_popularity),
      .rsp_last           (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   task automatic expect_answer(input logic [STATUS_W-1:0] status,
                                input logic [RANK_W-1:0] rank,
                                input logic [KEY_W-1:0] word,
                                input logic [LEN_W-1:0] len,
                                input logic [SCORE_W-1:0] score,
                                input logic last);
      list_answer_type a;
      a.status = status;
      a.rank   = rank;
      a.word   = word;
      a.len    = len;
      a.score  = score;
      a.last   = last;
      expected_answers.push_back(a);
   endtask

   task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                                input logic [LEN_W-1:0] len, input logic [SCORE_W-1:0] pop);
      word_request_type r;
      r.kind  = kind;
      r.key   = key;
      r.len   = len;
      r.pop   = pop;
      r.gap   = 0;
      r.drain = 1'b0;
      pending_requests.push_back(r);
   endtask

   // applies one accepted request to the predicted list and queues its answers
   task automatic update_ranked_list(input word_request_type r);
      logic [LEN_W-1:0] len;
      logic [KEY_W-1:0] word;
      int               pos;
      int               dup_at;
      int               shown;
      bit               full;
      case (r.kind)
         REQ_CLEAR: begin
            list_count = 0;
            expect_answer(ST_CLEARED, '0, '0, '0, '0, 1'b1);
         end
         REQ_DUMP: begin
            shown = (list_count < MAX_DUMP) ? list_count : MAX_DUMP;
            if (shown == 0) begin
               expect_answer(ST_EMPTY, '0, '0, '0, '0, 1'b1);
            end
            for (int i = 0; i < shown; i++) begin
               expect_answer(ST_ENTRY, RANK_W'(i), list_word[i], list_len[i], list_score[i],
                             i == shown - 1);
            end
         end
         REQ_INSERT: begin
            len  = (r.len > LEN_W'(WORD_BYTES)) ? LEN_W'(WORD_BYTES) : r.len;
            word = r.key;
            for (int b = 0; b < KEY_W / 8; b++) begin
               if (b >= len) word[b*8 +: 8] = 8'h00;
            end
            full   = (list_count == DEPTH);
            pos    = list_count;
            dup_at = -1;
            // match is tested before score at each rank, so later copies go unseen
            for (int i = 0; i < list_count; i++) begin
               if (pos == list_count && dup_at < 0) begin
                  if (list_len[i] == len && list_word[i] == word) dup_at = i;
                  else if (list_score[i] < r.pop) pos = i;
               end
            end
            if (full && r.pop <= list_score[DEPTH-1]) begin
               expect_answer(ST_TOO_LOW, '0, word, len, r.pop, 1'b1);
            end else if (dup_at >= 0) begin
               expect_answer(ST_DUPLICATE, RANK_W'(dup_at), word, len, r.pop, 1'b1);
            end else if (pos == list_count && full) begin
               expect_answer(ST_TOO_LOW, '0, word, len, r.pop, 1'b1);
            end else begin
               for (int j = full ? DEPTH - 1 : list_count; j > pos; j--) begin
                  list_word[j]  = list_word[j-1];
                  list_len[j]   = list_len[j-1];
                  list_score[j] = list_score[j-1];
               end
               list_word[pos]  = word;
               list_len[pos]   = len;
               list_score[pos] = r.pop;
               if (!full) list_count++;
               expect_answer(ST_INSERTED, RANK_W'(pos), word, len, r.pop, 1'b1);
            end
         end
         default: begin
            // reserved type: taken silently
         end
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      logic next_start;
      next_start = 1'b0;
      if (reset) begin
         gap_left  = 0;
         gap_armed = 1'b0;
      end else begin
         if (start && !busy) begin
            update_ranked_list(pending_requests.pop_front());
            gap_armed = 1'b0;
         end
         if (start && busy) begin
            next_start = 1'b1;
         end else if (pending_requests.size() > 0) begin
            if (!gap_armed) begin
               gap_left  = pending_requests[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (!(pending_requests[0].drain && expected_answers.size() > 0)) begin
               next_start     = 1'b1;
               req_type       <= pending_requests[0].kind;
               req_word_key   <= pending_requests[0].key;
               req_word_len   <= pending_requests[0].len;
               req_popularity <= pending_requests[0].pop;
            end
         end
      end
      start <= next_start;
   end

   // answer monitor
   always @(posedge clock) begin
      list_answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         answer_count++;
         if (expected_answers.size() == 0) begin
            flag_mismatch($sformatf("answer %0d arrived with none expected", answer_count));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("answer %0d status %0d, want %0d",
                                       answer_count, rsp_status, want.status));
            if (rsp_rank !== want.rank)
               flag_mismatch($sformatf("answer %0d rank %0d, want %0d",
                                       answer_count, rsp_rank, want.rank));
            if (rsp_out_word !== want.word)
               flag_mismatch($sformatf("answer %0d word %h, want %h",
                                       answer_count, rsp_out_word, want.word));
            if (rsp_out_len !== want.len)
               flag_mismatch($sformatf("answer %0d len %0d, want %0d",
                                       answer_count, rsp_out_len, want.len));
            if (rsp_out_popularity !== want.score)
               flag_mismatch($sformatf("answer %0d popularity %h, want %h",
                                       answer_count, rsp_out_popularity, want.score));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("answer %0d last %b, want %b",
                                       answer_count, rsp_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d answers outstanding", expected_answers.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0]   pool_key[POOL_SIZE];
      logic [LEN_W-1:0]   pool_len[POOL_SIZE];
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   len;
      logic [SCORE_W-1:0] pop;
      int                 counted;
      int                 roll;
      int                 pick;
      int                 last_at;

      // directed part
      queue_request(REQ_DUMP, '0, '0, '0);                          // empty dump
      queue_request(REQ_INSERT, '1, 4'd0, 32'h0);                   // empty word, zero score
      queue_request(REQ_INSERT, '1, 4'd15, 32'hFFFF_FFFF);          // long word, top score
      queue_request(REQ_INSERT, 64'h746163, 4'd3, 32'h0001_8000);
      queue_request(REQ_INSERT, 64'hDEAD_BEEF_0074_6163, 4'd3, 32'h4000); // match past len
      queue_request(REQ_INSERT, 64'h746163, 4'd4, 32'h0001_8000);   // equal score, other len
      queue_request(REQ_INSERT, 64'h41, 4'd1, 32'h0002_0000);
      queue_request(REQ_INSERT, 64'h0, 4'd0, 32'h0001_9000);        // late duplicate
      queue_request(REQ_INSERT, 64'h0123_4567_89AB_CDEF, 4'd9, 32'h100);
      queue_request(REQ_INSERT, 64'h55, 4'd2, 32'h100);             // list now full
      queue_request(REQ_INSERT, 64'h77, 4'd1, 32'h0);               // too low
      queue_request(REQ_INSERT, 64'h99, 4'd1, 32'h50);              // drops the last entry
      queue_request(REQ_DUMP, '0, '0, '0);
      pending_requests[pending_requests.size()-1].drain = 1'b1;
      queue_request(REQ_RESERVED, '1, 4'd15, '1);
      queue_request(REQ_INSERT, '1, 4'd8, 32'hFFFF_FFFF);           // duplicate at top
      queue_request(REQ_DUMP, '0, '0, '0);
      queue_request(REQ_CLEAR, '1, 4'd15, '1);
      queue_request(REQ_DUMP, '0, '0, '0);
      queue_request(REQ_INSERT, 64'h42, 4'd1, 32'h0);
      queue_request(REQ_CLEAR, '0, '0, '0);
      queue_request(REQ_INSERT, 64'h8000_0000_0000_0001, 4'd8, 32'h8000_0000);
      queue_request(REQ_DUMP, '0, '0, '0);

      // random part: a small word pool keeps duplicates and ties frequent
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_key[i] = {$urandom, $urandom};
         pool_len[i] = LEN_W'($urandom_range(0, 9));
      end
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            queue_request(REQ_CLEAR, {$urandom, $urandom}, LEN_W'($urandom), $urandom);
         end else if (roll < 14) begin
            queue_request(REQ_DUMP, {$urandom, $urandom}, LEN_W'($urandom), $urandom);
         end else if (roll < 17) begin
            queue_request(REQ_RESERVED, {$urandom, $urandom}, LEN_W'($urandom), $urandom);
         end else begin
            key = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0) begin
               pick = $urandom_range(0, POOL_SIZE - 1);
               len  = pool_len[pick];
               for (int b = 0; b < KEY_W / 8; b++) begin
                  if (b < len) key[b*8 +: 8] = pool_key[pick][b*8 +: 8];
               end
            end else begin
               len = LEN_W'($urandom_range(0, 15));
            end
            case ($urandom_range(0, 3))
               0: pop = $urandom;
               1: pop = SCORE_W'($urandom_range(0, 7)) << 16;
               2: pop = ($urandom_range(0, 1) == 0) ? '0 : '1;
               default: pop = SCORE_W'($urandom_range(0, 31));
            endcase
            queue_request(REQ_INSERT, key, len, pop);
         end
         last_at = pending_requests.size() - 1;
         // idle bursts come in alternating stretches, none near the end
         if (counted < RANDOM_ITEMS - CALM_TAIL && (counted / 40) % 2 == 0
             && $urandom_range(0, 9) < 3) begin
            pending_requests[last_at].gap = $urandom_range(1, 14);
         end
         if (counted == 100 || counted == 220) pending_requests[last_at].drain = 1'b1;
         if (pending_requests[last_at].kind != REQ_RESERVED) counted++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || start || expected_answers.size() > 0) begin
         @(posedge clock);
      end
      repeat (DEPTH + 4) @(posedge clock);
      if (expected_answers.size() > 0) flag_mismatch("answers still outstanding at end");

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tkw_pkg.sv
rtl/core/tkw_cell.sv
rtl/core/top_k_ranked_word_list_core.sv
dv/top_k_ranked_word_list_core_tb.sv
